// File: hw/rtl/dspv_pkg.sv
// shared types and constants for the date string parser and validator
`timescale 1ns / 1ps

package dspv_pkg;

	// character codes
	localparam logic [7:0] CH_NUL  = 8'd0;
	localparam logic [7:0] CH_DOT  = 8'd46;
	localparam logic [7:0] CH_ZERO = 8'd48;
	localparam logic [7:0] CH_NINE = 8'd57;

	// register reset value
	localparam logic [15:0] MIN_YEAR_RESET = 16'd1896;

	// calendar limits
	localparam logic [15:0] DAY_MAX        = 16'd31;
	localparam logic [15:0] MONTH_MAX      = 16'd12;
	localparam logic [15:0] FEB_DAYS_LEAP  = 16'd29;
	localparam logic [15:0] FEB_DAYS       = 16'd28;
	localparam logic [15:0] SHORT_MON_DAYS = 16'd30;

	// month codes with special lengths
	localparam logic [15:0] MON_FEB = 16'd2;
	localparam logic [15:0] MON_APR = 16'd4;
	localparam logic [15:0] MON_JUN = 16'd6;
	localparam logic [15:0] MON_SEP = 16'd9;
	localparam logic [15:0] MON_NOV = 16'd11;

	// year / 25 by reciprocal: floor(y * RECIP25 / 2^16) is y/25 or one above
	localparam int          RECIP_W  = 12;
	localparam logic [RECIP_W-1:0] RECIP25 = 12'd2622;
	localparam int          PROD_W   = 16 + RECIP_W;

	// fields collected by the parser when the string ends
	typedef struct packed {
		logic [15:0] day;
		logic [15:0] month;
		logic [15:0] year;
		logic        fmt_ok;
	} fields_t;

	// one result request
	typedef struct packed {
		logic [15:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic        date_ok;
	} result_t;

endpackage

// File: hw/rtl/date_string_parse_validate_top.sv
// top level of the dotted date string parser and validator
`timescale 1ns / 1ps

// Usage:
// Characters of a day.month.year string enter on the s_ stream, one byte per
// request. Digits build the current field (wrapping at 16 bits), a dot moves
// on to the next field, a NUL byte ends the string. Only the NUL produces a
// result request on the m_ stream: day, month and year, with date_ok in
// m_tuser, or all zeros when format or calendar check fails.
// Throughput is one character per cycle while s_tready is high. After the clock
// edge that accepted its NUL, one register holds the final fields, one holds
// the year times the reciprocal of 25, then comes the result register.
// The cfg_ channel writes min_year; it is always ready. The user must write it
// only while no string is in flight; the block itself does not enforce this.
// Reset clears the parse state and the pipeline and sets min_year to 1896.
// When the receiver stalls, the result holds in the output register and the
// two earlier stages keep filling; s_tready drops only when all are full.

module date_string_parse_validate_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [4:0] day_out, [8:5] month_out, [24:9] year_out, zeros
	output logic        m_tuser,   // [0] date_ok
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic              in_take;
	logic              valid_s1;
	logic              take_s1;
	dspv_pkg::fields_t fields_s1;
	dspv_pkg::result_t res;
	logic [15:0]       min_year_q;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_year_q <= dspv_pkg::MIN_YEAR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			min_year_q <= cfg_data;
		end
	end

	// input handshake
	assign s_tready = !valid_s1 || take_s1;
	assign in_take  = s_tvalid && s_tready;

	dspv_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_take   (in_take),
		.char_code (s_tdata),
		.take_s1   (take_s1),
		.valid_s1  (valid_s1),
		.fields_s1 (fields_s1)
	);

	dspv_check u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.fields_s1 (fields_s1),
		.min_year  (min_year_q),
		.out_ready (m_tready),
		.take_s1   (take_s1),
		.out_valid (m_tvalid),
		.out_res   (res)
	);

	// output packing
	assign m_tdata = {7'd0, res.year, res.month, res.day};
	assign m_tuser = res.date_ok;

	// a valid date never carries a zero day or a month out of range
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata[4:0] != 5'd0) && (m_tdata[8:5] != 4'd0) &&
			(m_tdata[8:5] <= 4'd12))
		else $error("valid date with bad day or month");

	// a failed date is reported as all zeros
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> (m_tdata == 32'd0))
		else $error("failed date with nonzero fields");

	// an empty output register means the pipeline drains and input is open
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with empty output");

endmodule

// File: hw/rtl/dspv_parse.sv
// character parser: accumulates day, month and year fields of a dotted date
`timescale 1ns / 1ps

module dspv_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_take,
	input  logic [7:0]        char_code,
	input  logic              take_s1,
	output logic              valid_s1,
	output dspv_pkg::fields_t fields_s1
);

	typedef enum logic [1:0] {
		FLD_DAY,
		FLD_MONTH,
		FLD_YEAR
	} field_t;

	field_t      field_q;
	logic [15:0] day_q;
	logic [15:0] month_q;
	logic [15:0] year_q;
	logic        bad_q;

	logic        is_digit;
	logic        is_dot;
	logic        is_nul;
	logic [7:0]  digit_full;
	logic [15:0] cur_acc;
	logic [15:0] pushed;

	// character classes
	assign is_digit   = (char_code >= dspv_pkg::CH_ZERO) && (char_code <= dspv_pkg::CH_NINE);
	assign is_dot     = (char_code == dspv_pkg::CH_DOT);
	assign is_nul     = (char_code == dspv_pkg::CH_NUL);
	assign digit_full = char_code - dspv_pkg::CH_ZERO;

	// current field times ten plus digit, wrapping at 16 bits
	always_comb begin
		case (field_q)
			FLD_DAY:   cur_acc = day_q;
			FLD_MONTH: cur_acc = month_q;
			default:   cur_acc = year_q;
		endcase
		pushed = (cur_acc << 3) + (cur_acc << 1) + {12'd0, digit_full[3:0]};
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_q <= FLD_DAY;
			day_q   <= '0;
			month_q <= '0;
			year_q  <= '0;
			bad_q   <= 1'b0;
		end else if (in_take) begin
			if (is_digit) begin
				unique case (field_q)
					FLD_DAY:   day_q   <= pushed;
					FLD_MONTH: month_q <= pushed;
					FLD_YEAR:  year_q  <= pushed;
					default:   bad_q   <= 1'b1;
				endcase
			end else if (is_dot) begin
				unique case (field_q)
					FLD_DAY:   field_q <= FLD_MONTH;
					FLD_MONTH: field_q <= FLD_YEAR;
					default:   bad_q   <= 1'b1;
				endcase
			end else if (!is_nul) begin
				bad_q <= 1'b1;
			end else begin
				field_q <= FLD_DAY;
				day_q   <= '0;
				month_q <= '0;
				year_q  <= '0;
				bad_q   <= 1'b0;
			end
		end
	end

	// end-of-string stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (in_take && is_nul) || (valid_s1 && !take_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_take && is_nul) begin
			fields_s1.day    <= day_q;
			fields_s1.month  <= month_q;
			fields_s1.year   <= year_q;
			fields_s1.fmt_ok <= !bad_q && (field_q == FLD_YEAR);
		end
	end

endmodule

// File: hw/rtl/dspv_check.sv
// calendar check pipeline: leap year, month length, day and month range and minimum year
`timescale 1ns / 1ps

module dspv_check (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  dspv_pkg::fields_t fields_s1,
	input  logic [15:0]       min_year,
	input  logic              out_ready,
	output logic              take_s1,
	output logic              out_valid,
	output dspv_pkg::result_t out_res
);

	localparam int PW = dspv_pkg::PROD_W;

	logic              valid_s2;
	dspv_pkg::fields_t fields_s2;
	logic [PW-1:0]     prod_s2;
	logic              adv_out;
	logic              take_s2;

	logic [11:0]       quot;
	logic [16:0]       q25;
	logic [16:0]       diff;
	logic              mod25_zero;
	logic              mod4_zero;
	logic              mod16_zero;
	logic              leap;
	logic [15:0]       month_days;
	logic              cal_ok;
	logic              ok;

	// stage handshakes
	assign adv_out = !out_valid || out_ready;
	assign take_s2 = valid_s2 && adv_out;
	assign take_s1 = !valid_s2 || adv_out;

	// stage 2: year times reciprocal of 25
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (take_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && valid_s1) begin
			fields_s2 <= fields_s1;
			prod_s2   <= fields_s1.year * dspv_pkg::RECIP25;
		end
	end

	// remainder by 25 is zero when the difference is zero or minus 25
	always_comb begin
		quot       = prod_s2[PW-1:16];
		q25        = {1'b0, quot, 4'd0} + {2'b0, quot, 3'd0} + {5'd0, quot};
		diff       = {1'b0, fields_s2.year} - q25;
		mod25_zero = (diff == 17'd0) || (diff == (17'd0 - 17'd25));
		mod4_zero  = (fields_s2.year[1:0] == 2'd0);
		mod16_zero = (fields_s2.year[3:0] == 4'd0);
		leap       = (mod16_zero && mod25_zero) || (mod4_zero && !mod25_zero);
	end

	// month length and range checks
	always_comb begin
		case (fields_s2.month) inside
			dspv_pkg::MON_FEB:
				month_days = leap ? dspv_pkg::FEB_DAYS_LEAP : dspv_pkg::FEB_DAYS;
			dspv_pkg::MON_APR, dspv_pkg::MON_JUN, dspv_pkg::MON_SEP, dspv_pkg::MON_NOV:
				month_days = dspv_pkg::SHORT_MON_DAYS;
			default:
				month_days = dspv_pkg::DAY_MAX;
		endcase
		cal_ok = (fields_s2.day != 16'd0) && (fields_s2.day <= month_days) &&
			(fields_s2.month != 16'd0) && (fields_s2.month <= dspv_pkg::MONTH_MAX) &&
			(fields_s2.year >= min_year);
		ok = fields_s2.fmt_ok && cal_ok;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv_out) begin
			out_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s2) begin
			out_res.day     <= ok ? fields_s2.day[4:0] : 5'd0;
			out_res.month   <= ok ? fields_s2.month[3:0] : 4'd0;
			out_res.year    <= ok ? fields_s2.year : 16'd0;
			out_res.date_ok <= ok;
		end
	end

endmodule

// File: dv/date_result_checker.sv
// checker for the date parser: predicts each result from the character stream and compares
`timescale 1ns / 1ps

module date_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // [4:0] day_out, [8:5] month_out, [24:9] year_out, zeros
	input  logic        m_tuser,   // [0] date_ok
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          waiting
);

	typedef enum logic [1:0] {
		FIELD_DAY,
		FIELD_MONTH,
		FIELD_YEAR
	} field_t;

	field_t            field_sel;
	logic [15:0]       day_acc;
	logic [15:0]       month_acc;
	logic [15:0]       year_acc;
	logic [15:0]       year_floor;
	logic              text_bad;
	dspv_pkg::result_t expected_dates[$];

	// gregorian leap rule
	function automatic logic is_leap(input logic [15:0] y);
		return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
	endfunction

	// range, minimum year and month length checks
	function automatic logic calendar_valid(input logic [15:0] d, input logic [15:0] m,
			input logic [15:0] y, input logic [15:0] floor_year);
		logic [15:0] last_day;
		if (d < 1 || d > dspv_pkg::DAY_MAX)
			return 1'b0;
		if (m < 1 || m > dspv_pkg::MONTH_MAX)
			return 1'b0;
		if (y < floor_year)
			return 1'b0;
		if (m == dspv_pkg::MON_FEB)
			last_day = is_leap(y) ? dspv_pkg::FEB_DAYS_LEAP : dspv_pkg::FEB_DAYS;
		else if (m == dspv_pkg::MON_APR || m == dspv_pkg::MON_JUN ||
				m == dspv_pkg::MON_SEP || m == dspv_pkg::MON_NOV)
			last_day = dspv_pkg::SHORT_MON_DAYS;
		else
			last_day = dspv_pkg::DAY_MAX;
		return d <= last_day;
	endfunction

	// decimal shift-in, wrapping at 16 bits
	function automatic logic [15:0] shift_in_digit(input logic [15:0] acc, input logic [7:0] ch);
		logic [31:0] wide;
		wide = 32'(acc) * 32'd10 + 32'(ch - dspv_pkg::CH_ZERO);
		return wide[15:0];
	endfunction

	// parse state, result queue and comparison
	always @(posedge clk or negedge arst_n) begin : watch
		dspv_pkg::result_t got;
		dspv_pkg::result_t want;
		if (!arst_n) begin
			field_sel  <= FIELD_DAY;
			day_acc    <= '0;
			month_acc  <= '0;
			year_acc   <= '0;
			text_bad   <= 1'b0;
			year_floor <= dspv_pkg::MIN_YEAR_RESET;
			expected_dates.delete();
			fail_count = 0;
			waiting    <= 0;
		end else begin
			// register write
			if (cfg_valid && cfg_ready)
				year_floor <= cfg_data;

			// result request against the oldest prediction
			if (m_tvalid && m_tready) begin
				got.day     = m_tdata[4:0];
				got.month   = m_tdata[8:5];
				got.year    = m_tdata[24:9];
				got.date_ok = m_tuser;
				if (expected_dates.size() == 0) begin
					$display("%0t: result with none pending: day %0d month %0d year %0d ok %0b",
						$time, got.day, got.month, got.year, got.date_ok);
					fail_count = fail_count + 1;
				end else begin
					want = expected_dates.pop_front();
					if (got !== want || m_tdata[31:25] !== '0) begin
						$display("%0t: wrong result: exp day %0d month %0d year %0d ok %0b",
							$time, want.day, want.month, want.year, want.date_ok);
						$display("%0t:               got day %0d month %0d year %0d ok %0b pad %h",
							$time, got.day, got.month, got.year, got.date_ok, m_tdata[31:25]);
						fail_count = fail_count + 1;
					end
				end
			end

			// character request advances the parse
			if (s_tvalid && s_tready) begin
				if (s_tdata >= dspv_pkg::CH_ZERO && s_tdata <= dspv_pkg::CH_NINE) begin
					case (field_sel)
						FIELD_DAY:   day_acc   <= shift_in_digit(day_acc, s_tdata);
						FIELD_MONTH: month_acc <= shift_in_digit(month_acc, s_tdata);
						FIELD_YEAR:  year_acc  <= shift_in_digit(year_acc, s_tdata);
						default:     text_bad  <= 1'b1;
					endcase
				end else if (s_tdata == dspv_pkg::CH_DOT) begin
					if (field_sel == FIELD_DAY || field_sel == FIELD_MONTH)
						field_sel <= field_t'(field_sel + 2'd1);
					else
						text_bad <= 1'b1;
				end else if (s_tdata != dspv_pkg::CH_NUL) begin
					text_bad <= 1'b1;
				end else begin
					// end of string: one result, then a fresh parse
					want = '0;
					if (!text_bad && field_sel == FIELD_YEAR &&
							calendar_valid(day_acc, month_acc, year_acc, year_floor)) begin
						want.day     = day_acc[4:0];
						want.month   = month_acc[3:0];
						want.year    = year_acc;
						want.date_ok = 1'b1;
					end
					expected_dates.push_back(want);
					field_sel <= FIELD_DAY;
					day_acc   <= '0;
					month_acc <= '0;
					year_acc  <= '0;
					text_bad  <= 1'b0;
				end
			end

			waiting <= expected_dates.size();
		end
	end

endmodule

// File: dv/tb_date_string_parse_validate_top.sv
// testbench top for the date parser: character stimulus, sink stalls and the verdict
`timescale 1ns / 1ps

module tb_date_string_parse_validate_top;

	localparam int CYCLE_LIMIT = 400000;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic [7:0]  s_tdata   = 8'd0;
	logic        m_tready  = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [15:0] cfg_data  = 16'd0;
	logic        s_tready;
	logic        m_tvalid;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        cfg_ready;

	int          fail_count;
	int          waiting;
	int          src_idle_pct  = 0;
	int          sink_idle_pct = 0;
	int          cycles        = 0;
	int          chars_sent    = 0;
	logic [15:0] min_year_now  = dspv_pkg::MIN_YEAR_RESET;
	logic [7:0]  text_q[$];

	always #1 clk = ~clk;

	date_string_parse_validate_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	date_result_checker date_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.waiting    (waiting)
	);

	// sink side stalls
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
	end

	// run watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("date_string_parse_validate_top: mismatch");
			$finish;
		end
	end

	// one character request, with random gaps ahead of it
	task automatic push_char(input logic [7:0] ch);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 8'($urandom);
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		do @(posedge clk); while (!s_tready);
		chars_sent++;
	endtask

	// send the built text and its terminating nul
	task automatic send_text();
		foreach (text_q[i])
			push_char(text_q[i]);
		push_char(dspv_pkg::CH_NUL);
		text_q.delete();
	endtask

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			text_q.push_back(8'(s[i]));
	endtask

	// decimal field, sometimes with leading zeros
	task automatic add_number(input int unsigned v);
		string digits;
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 3)) text_q.push_back(dspv_pkg::CH_ZERO);
		digits = $sformatf("%0d", v);
		add_str(digits);
	endtask

	task automatic directed(input string s);
		add_str(s);
		send_text();
	endtask

	// hold the sender until every result is back
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (waiting != 0);
	endtask

	task automatic set_min_year(input logic [15:0] v);
		drain();
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		min_year_now = v;
	endtask

	// days weighted toward month ends, some out of range or wrapping
	function automatic int unsigned pick_day();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return $urandom_range(0, 99);
		if (r < 15)
			return 32'd65536 + $urandom_range(0, 40);
		if (r < 45)
			return $urandom_range(28, 31);
		return $urandom_range(1, 31);
	endfunction

	// months weighted toward the short ones
	function automatic int unsigned pick_month();
		int unsigned short_months[5] = '{2, 4, 6, 9, 11};
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return $urandom_range(0, 20);
		if (r < 12)
			return 32'd65536 + $urandom_range(0, 13);
		if (r < 40)
			return short_months[$urandom_range(0, 4)];
		return $urandom_range(1, 12);
	endfunction

	// years near the floor, on leap boundaries, anywhere, or wrapping
	function automatic int unsigned pick_year();
		int          near;
		int unsigned y;
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			near = int'(min_year_now) + int'($urandom_range(0, 6)) - 3;
			if (near < 0)
				near = 0;
			if (near > 65535)
				near = 65535;
			return near;
		end
		if (r < 75) begin
			y = $urandom_range(1, 3000);
			case ($urandom_range(0, 3))
				0: y = y - y % 4;
				1: y = y - y % 100;
				2: y = y - y % 400;
				default: ;
			endcase
			return y;
		end
		if (r < 95)
			return $urandom_range(0, 65535);
		return $urandom_range(65536, 400000);
	endfunction

	// mostly well-formed dates, some corrupted, the rest noise
	task automatic random_date();
		int unsigned r;
		int unsigned pos;
		r = $urandom_range(0, 99);
		if (r < 75) begin
			if ($urandom_range(0, 19) != 0)
				add_number(pick_day());
			text_q.push_back(dspv_pkg::CH_DOT);
			if ($urandom_range(0, 19) != 0)
				add_number(pick_month());
			text_q.push_back(dspv_pkg::CH_DOT);
			if ($urandom_range(0, 19) != 0)
				add_number(pick_year());
			if ($urandom_range(0, 9) == 0) begin
				pos = $urandom_range(0, text_q.size());
				text_q.insert(pos, 8'($urandom_range(0, 255)));
			end
		end else begin
			repeat ($urandom_range(0, 10)) begin
				r = $urandom_range(0, 99);
				if (r < 45)
					text_q.push_back(dspv_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
				else if (r < 65)
					text_q.push_back(dspv_pkg::CH_DOT);
				else
					text_q.push_back(8'($urandom_range(0, 255)));
			end
		end
		send_text();
	endtask

	task automatic random_block(input int n_chars, input logic [15:0] floor_year);
		int stop_at;
		set_min_year(floor_year);
		stop_at = chars_sent + n_chars;
		while (chars_sent < stop_at) begin
			random_date();
			if ($urandom_range(0, 24) == 0)
				drain();
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		src_idle_pct  = 8;
		sink_idle_pct = 72;

		// calendar edges under the reset minimum year
		directed("31.12.1896");
		directed("29.2.2000");
		directed("29.2.1900");
		directed("29.02.2024");
		directed("29.2.2023");
		directed("31.4.2001");
		directed("31.7.2001");
		directed("1.1.1895");
		directed("32.1.2000");
		directed("1.13.2000");
		// empty fields, format faults, wrap
		directed("..2000");
		directed("1.2.2000.5");
		directed("1a.1.2000");
		directed("12.5");
		directed("");
		directed("65537.65548.1999");
		directed("7.3.99999");
		directed("0.0.0");
		text_q.push_back(8'hFF);
		directed("1.1.2000");
		// empty year passes only with a zero floor
		set_min_year(16'd0);
		directed("1.1.");
		directed("31.12.0");

		random_block(120, 16'd2000);
		random_block(120, 16'd65535);

		src_idle_pct  = 72;
		sink_idle_pct = 8;
		random_block(120, 16'($urandom_range(1500, 2500)));
		random_block(120, 16'($urandom));

		src_idle_pct  = 0;
		sink_idle_pct = 0;
		random_block(120, 16'd0);
		random_block(120, dspv_pkg::MIN_YEAR_RESET);

		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("date_string_parse_validate_top: match");
		else
			$display("date_string_parse_validate_top: mismatch");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/dspv_pkg.sv
hw/rtl/dspv_parse.sv
hw/rtl/dspv_check.sv
hw/rtl/date_string_parse_validate_top.sv
dv/date_result_checker.sv
dv/tb_date_string_parse_validate_top.sv
